### hw/rtl/ole_pkg.sv
// Shared types and codes for the ordered list engine.
// No dependencies; imported by the ordered_list_engine top level.
package ole_pkg;

  // Request type codes.
  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_READ   = 3'd2;
  localparam logic [2:0] REQ_WRITE  = 3'd3;
  localparam logic [2:0] REQ_SEARCH = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // One request as captured at acceptance.
  typedef struct packed {
    logic [2:0]  req;
    logic [8:0]  pos;
    logic [31:0] val;
  } ole_req_t;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_CHECK    = 7'b0000010,
    S_FETCH    = 7'b0000100,
    S_SHIFT_UP = 7'b0001000,
    S_SHIFT_DN = 7'b0010000,
    S_INS_PUT  = 7'b0100000,
    S_SEARCH   = 7'b1000000
  } ole_state_t;

endpackage

### hw/rtl/ole_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies; used by ordered_list_engine for the entry store.
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/ordered_list_engine.sv
// Ordered list engine top level: request decode, sequencer and entry count.
// Depends on ole_pkg and on ole_ram, which holds the list entries.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------------------
//  request  | in        | start, busy            | in_req_type, in_position, in_value
//  result   | out       | out_valid (one cycle)  | out_status, out_data_out,
//           |           |                        | out_found_position, out_list_length
//
// Every entry access goes through the single RAM read port, one entry per cycle. Write
// and errors finish in the check step; read adds a fetch; insert at position p shifts
// the entries from p to the tail up one slot; remove shifts those behind p down; search
// reads from the head to a match or the tail (an empty list misses in the check step).
// busy drops in the cycle of the result strobe, so the next transaction can start there.
// Reset clears the sequencer and the length; the entry store is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module ordered_list_engine #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [8:0]  in_position,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_data_out,
  output logic [8:0]  out_found_position,
  output logic [8:0]  out_list_length
);

  import ole_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 9) ? CW : 9;
  localparam int SW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  ole_state_t      state_r, state_nxt;
  ole_req_t        req_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [31:0]     out_data_r, out_data_nxt;
  logic [8:0]      out_found_r, out_found_nxt;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [SW-1:0]   mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [SW-1:0]   mem_rdata;

  logic [XW-1:0]   pos_x;
  logic [XW-1:0]   cnt_x;
  logic [CW-1:0]   pos_c;
  logic [SW-1:0]   val_s;
  logic            pos_in_range;
  logic            ins_pos_ok;
  logic            list_full;
  logic            accept;

  assign accept       = start && !busy;
  assign pos_x        = XW'(req_r.pos);
  assign cnt_x        = XW'(count_r);
  // Truncation is safe: pos_c is used only once the position is known to be in range.
  assign pos_c        = CW'(req_r.pos);
  assign val_s        = req_r.val[SW-1:0];
  assign pos_in_range = (pos_x != '0) && (pos_x <= cnt_x);
  assign ins_pos_ok   = pos_x <= cnt_x;
  assign list_full    = count_r == CW'(CAPACITY);

  ole_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_found_nxt  = out_found_r;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r[AW-1:0];
    mem_wdata      = mem_rdata;
    mem_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_status_nxt = ST_OK;
          out_data_nxt   = '0;
          out_found_nxt  = '0;
          state_nxt      = S_CHECK;
        end
      end

      S_CHECK: begin
        unique case (req_r.req)
          REQ_INSERT: begin
            if (!ins_pos_ok) begin
              out_status_nxt = ST_RANGE;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else if (list_full) begin
              out_status_nxt = ST_FULL;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else if (pos_x == cnt_x) begin
              state_nxt = S_INS_PUT;
            end else begin
              // Walk from the tail toward the insert point, one entry up per cycle.
              mem_raddr = AW'(count_r - 1'b1);
              ptr_nxt   = count_r;
              state_nxt = S_SHIFT_UP;
            end
          end
          REQ_REMOVE, REQ_READ: begin
            if (!pos_in_range) begin
              out_status_nxt = ST_RANGE;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              mem_raddr = AW'(pos_c - 1'b1);
              state_nxt = S_FETCH;
            end
          end
          REQ_WRITE: begin
            if (!pos_in_range) begin
              out_status_nxt = ST_RANGE;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(pos_c - 1'b1);
              mem_wdata = val_s;
            end
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
          REQ_SEARCH: begin
            if (count_r == '0) begin
              out_status_nxt = ST_NOTFOUND;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              mem_raddr = '0;
              ptr_nxt   = '0;
              state_nxt = S_SEARCH;
            end
          end
          default: begin
            out_status_nxt = ST_RANGE;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end
        endcase
      end

      S_FETCH: begin
        out_data_nxt = 32'(mem_rdata);
        if (req_r.req == REQ_READ) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (pos_x == cnt_x) begin
          // Removing the tail needs no shift.
          count_nxt     = count_r - 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ptr_nxt   = pos_c - 1'b1;
          mem_raddr = AW'(pos_c);
          state_nxt = S_SHIFT_DN;
        end
      end

      S_SHIFT_DN: begin
        // The data read last cycle belongs one slot below where it was.
        mem_we = 1'b1;
        if (ptr_r + 2'd2 == count_r) begin
          count_nxt     = count_r - 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ptr_nxt   = ptr_r + 1'b1;
          mem_raddr = AW'(ptr_r + 2'd2);
        end
      end

      S_SHIFT_UP: begin
        // The write address trails the read address by two, so they never collide.
        mem_we = 1'b1;
        if (ptr_r == pos_c + 1'b1) begin
          state_nxt = S_INS_PUT;
        end else begin
          ptr_nxt   = ptr_r - 1'b1;
          mem_raddr = AW'(ptr_r - 2'd2);
        end
      end

      S_INS_PUT: begin
        mem_we        = 1'b1;
        mem_waddr     = AW'(pos_c);
        mem_wdata     = val_s;
        count_nxt     = count_r + 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_SEARCH: begin
        if (mem_rdata == val_s) begin
          out_found_nxt = 9'(ptr_r + 1'b1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (ptr_r + 1'b1 == count_r) begin
          out_status_nxt = ST_NOTFOUND;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          ptr_nxt   = ptr_r + 1'b1;
          mem_raddr = AW'(ptr_r + 1'b1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.req <= in_req_type;
      req_r.pos <= in_position;
      req_r.val <= in_value;
    end
    ptr_r        <= ptr_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign busy               = state_r != S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_data_out       = out_data_r;
  assign out_found_position = out_found_r;
  assign out_list_length    = 9'(count_r);

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while the sequencer is still busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list length exceeds capacity");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CHECK))
    else $error("accepted transaction did not enter the check step");

  a_shift_up_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_UP) |-> (XW'(ptr_r) > pos_x))
    else $error("insert shift pointer passed the insert point");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (req_r.req == REQ_INSERT) && (out_status_r == ST_OK))
      |-> (count_r == CW'($past(count_r) + 1'b1)))
    else $error("successful insert did not grow the list by one");

endmodule

### dv/ordered_list_engine_test.sv
// Self-checking testbench for ordered_list_engine: directed and random list requests
// checked against a behavioral mirror of the list. Depends on ole_pkg and the RTL top.
`timescale 1ns / 100ps

module ordered_list_engine_test;
  import ole_pkg::*;

  localparam int LIST_CAPACITY = 256;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_req_type;
  logic [8:0]  in_position;
  logic [31:0] in_value;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_data_out;
  logic [8:0]  out_found_position;
  logic [8:0]  out_list_length;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] data;
    logic [8:0]  found;
    logic [8:0]  length;
  } list_outcome_t;

  // Mirror of the list contents; predicts the outcome of each accepted request.
  class ordered_list_mirror;
    logic [31:0]   entries [0:LIST_CAPACITY-1];
    int unsigned   stored;
    list_outcome_t pending_outcomes[$];
    int            errors;

    function new();
      stored = 0;
      errors = 0;
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    function void apply_request(ole_req_t r);
      list_outcome_t o;
      o.status = ST_OK;
      o.data   = '0;
      o.found  = '0;
      case (r.req)
        REQ_INSERT: begin
          if (r.pos > stored) begin
            o.status = ST_RANGE;
          end else if (stored >= LIST_CAPACITY) begin
            o.status = ST_FULL;
          end else begin
            for (int k = stored; k > r.pos; k--) entries[k] = entries[k-1];
            entries[r.pos] = r.val;
            stored++;
          end
        end
        REQ_REMOVE: begin
          if (r.pos == 0 || r.pos > stored) begin
            o.status = ST_RANGE;
          end else begin
            o.data = entries[r.pos-1];
            for (int k = r.pos - 1; k + 1 < stored; k++) entries[k] = entries[k+1];
            stored--;
          end
        end
        REQ_READ: begin
          if (r.pos == 0 || r.pos > stored) o.status = ST_RANGE;
          else o.data = entries[r.pos-1];
        end
        REQ_WRITE: begin
          if (r.pos == 0 || r.pos > stored) o.status = ST_RANGE;
          else entries[r.pos-1] = r.val;
        end
        REQ_SEARCH: begin
          o.status = ST_NOTFOUND;
          for (int k = 0; k < stored; k++) begin
            if (entries[k] == r.val) begin
              o.found  = 9'(k + 1);
              o.status = ST_OK;
              break;
            end
          end
        end
        default: o.status = ST_RANGE;
      endcase
      o.length = stored[8:0];
      pending_outcomes.push_back(o);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_outcome(logic [1:0] st, logic [31:0] d, logic [8:0] fp,
                                logic [8:0] len);
      list_outcome_t o;
      if (pending_outcomes.size() == 0) begin
        $error("result with no request outstanding: status 0x%0h", st);
        errors++;
        return;
      end
      o = pending_outcomes.pop_front();
      compare_field("status", 32'(o.status), 32'(st));
      compare_field("data_out", o.data, d);
      compare_field("found_position", 32'(o.found), 32'(fp));
      compare_field("list_length", 32'(o.length), 32'(len));
    endfunction
  endclass

  ordered_list_mirror mirror;
  bit                 steady;

  ordered_list_engine #(
    .CAPACITY  (LIST_CAPACITY),
    .DATA_WIDTH(32)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_data_out      (out_data_out),
    .out_found_position(out_found_position),
    .out_list_length   (out_list_length)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Results cannot be held off, so every strobe is a completed transaction.
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0)
      mirror.check_outcome(out_status, out_data_out, out_found_position, out_list_length);
  end

  task automatic send_request(input logic [2:0] req, input logic [8:0] pos,
                              input logic [31:0] val);
    ole_req_t r;
    r.req = req;
    r.pos = pos;
    r.val = val;
    @(negedge clk);
    start       <= 1'b1;
    in_req_type <= req;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (busy !== 1'b0);
    mirror.apply_request(r);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start       <= 1'b0;
      in_req_type <= 3'($urandom_range(0, 7));
      in_position <= 9'($urandom_range(0, 511));
      in_value    <= $urandom;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (mirror.pending() != 0) @(negedge clk);
  endtask

  // One random request, mostly well formed for the current list length.
  task automatic random_request(input int ins_pct, input int rem_pct);
    int          roll;
    logic [2:0]  req;
    logic [8:0]  pos;
    logic [31:0] val;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) req = REQ_INSERT;
    else if (roll < ins_pct + rem_pct) req = REQ_REMOVE;
    else if ($urandom_range(0, 99) < 4) req = 3'($urandom_range(5, 7));
    else begin
      case ($urandom_range(0, 2))
        0:       req = REQ_READ;
        1:       req = REQ_WRITE;
        default: req = REQ_SEARCH;
      endcase
    end
    if ($urandom_range(0, 99) < 8) pos = 9'($urandom_range(0, 511));
    else if (req == REQ_INSERT) pos = 9'($urandom_range(0, mirror.stored));
    else if (mirror.stored == 0) pos = 1;
    else pos = 9'($urandom_range(1, mirror.stored));
    case ($urandom_range(0, 9))
      0:       val = 32'h0000_0000;
      1:       val = 32'hFFFF_FFFF;
      2, 3, 4: val = 32'($urandom_range(0, 15));
      default: val = $urandom;
    endcase
    if (req == REQ_SEARCH && mirror.stored > 0 && $urandom_range(0, 99) < 60)
      val = mirror.entries[$urandom_range(0, mirror.stored - 1)];
    if (!steady && $urandom_range(0, 99) < 20) begin
      if ($urandom_range(0, 9) == 0) idle_cycles($urandom_range(7, 60));
      else idle_cycles($urandom_range(1, 6));
    end
    send_request(req, pos, val);
  endtask

  initial begin
    #10_000_000;
    $display("ordered_list_engine regression: fail");
    $finish;
  end

  initial begin
    mirror      = new();
    steady      = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req_type = '0;
    in_position = '0;
    in_value    = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Empty list: every position is out of range and searches miss.
    send_request(REQ_SEARCH, 9'd0, 32'h0000_0000);
    send_request(REQ_READ, 9'd1, 32'h0);
    send_request(REQ_REMOVE, 9'd0, 32'h0);
    send_request(REQ_WRITE, 9'd0, 32'h1234_5678);
    send_request(REQ_INSERT, 9'd1, 32'h1);
    // Build a three entry list at the front, the back and the front again.
    send_request(REQ_INSERT, 9'd0, 32'h0000_0000);
    send_request(REQ_INSERT, 9'd1, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 9'd0, 32'h5A5A_A5A5);
    send_request(REQ_READ, 9'd1, 32'h0);
    send_request(REQ_READ, 9'd2, 32'h0);
    send_request(REQ_READ, 9'd3, 32'h0);
    send_request(REQ_READ, 9'd4, 32'h0);
    send_request(REQ_READ, 9'd511, 32'h0);
    send_request(REQ_WRITE, 9'd2, 32'hDEAD_BEEF);
    send_request(REQ_SEARCH, 9'd0, 32'hDEAD_BEEF);
    send_request(REQ_SEARCH, 9'd0, 32'hFFFF_FFFF);
    send_request(REQ_SEARCH, 9'd7, 32'h0001_2345);
    send_request(REQ_INSERT, 9'd511, 32'h0);
    send_request(3'd5, 9'd1, 32'h0);
    send_request(3'd6, 9'd0, 32'hFFFF_FFFF);
    send_request(3'd7, 9'd2, 32'h0);
    send_request(REQ_REMOVE, 9'd3, 32'h0);
    send_request(REQ_REMOVE, 9'd1, 32'h0);
    send_request(REQ_REMOVE, 9'd1, 32'h0);
    send_request(REQ_REMOVE, 9'd1, 32'h0);

    // Balanced traffic on a short list.
    repeat (40) random_request(40, 35);

    // Grow to capacity with no idle gaps, then keep pushing into the full list.
    steady = 1'b1;
    while (mirror.stored < LIST_CAPACITY) random_request(75, 5);
    repeat (20) random_request(80, 5);
    steady = 1'b0;

    wait_drained();

    // Drain the list back down, then finish with short-list traffic.
    while (mirror.stored > 2) random_request(5, 75);
    repeat (20) random_request(40, 40);

    wait_drained();
    repeat (300) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("ordered_list_engine regression: pass");
    end else begin
      $display("ordered_list_engine regression: fail");
    end
    $finish;
  end

endmodule
